### rtl/text_console_writer_unit_assert.svh
// Assertion macros used by the text console writer top level.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcw assertion failed");

// Next-cycle implication, checked out of reset.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw assertion failed");

`endif

### rtl/tcw_pkg.sv
// Types, constants and helper functions for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = COLUMNS * ROWS;

    // Port widths
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int COL_IN_W = 7;
    localparam int ROW_IN_W = 5;
    localparam int OFF_W    = 11;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;

    // Internal widths
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CT_W   = $clog2(COLUMNS + TAB_STOP);

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SET   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic do_put;
        logic do_clear;
        logic do_set;
        logic rd_cell;
        logic scroll_start;
        logic scroll_rd;
        logic scroll_wr;
        logic fill_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_code_t item_cmd;
        logic      put_scroll;
        logic      move_last;
        logic      fill_last;
        logic      out_busy;
    } dp_stat_t;

    function automatic logic [COL_W-1:0] sat_col(input logic [COL_IN_W-1:0] c);
        logic [COL_W-1:0] r;
        if (int'(c) >= COLUMNS)
            r = COL_W'(COLUMNS - 1);
        else
            r = COL_W'(c);
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] sat_row(input logic [ROW_IN_W-1:0] r_in);
        logic [ROW_W-1:0] r;
        if (int'(r_in) >= ROWS)
            r = ROW_W'(ROWS - 1);
        else
            r = ROW_W'(r_in);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(r) * ADDR_W'(COLUMNS);
        return base + ADDR_W'(c);
    endfunction

endpackage

### rtl/tcw_ctrl.sv
// Controller state machine: sequences put, clear, scroll, set and read items.
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tcw_pkg::dp_stat_t   stat,
    output tcw_pkg::ctrl_cmd_t  cmd
);

    tcw_pkg::ctrl_state_t state_reg;
    tcw_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tcw_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = tcw_pkg::ST_DISPATCH;
                end
            end
            tcw_pkg::ST_DISPATCH:
            begin
                case (stat.item_cmd)
                    tcw_pkg::CMD_PUT:
                    begin
                        cmd.do_put = 1'b1;
                        if (stat.put_scroll)
                        begin
                            cmd.scroll_start = 1'b1;
                            state_next       = tcw_pkg::ST_SCROLL_RD;
                        end
                        else
                        begin
                            state_next = tcw_pkg::ST_DONE;
                        end
                    end
                    tcw_pkg::CMD_CLEAR:
                    begin
                        cmd.do_clear = 1'b1;
                        state_next   = tcw_pkg::ST_FILL;
                    end
                    tcw_pkg::CMD_SET:
                    begin
                        cmd.do_set = 1'b1;
                        state_next = tcw_pkg::ST_DONE;
                    end
                    tcw_pkg::CMD_READ:
                    begin
                        cmd.rd_cell = 1'b1;
                        state_next  = tcw_pkg::ST_DONE;
                    end
                    default:
                    begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                endcase
            end
            tcw_pkg::ST_SCROLL_RD:
            begin
                cmd.scroll_rd = 1'b1;
                state_next    = tcw_pkg::ST_SCROLL_WR;
            end
            tcw_pkg::ST_SCROLL_WR:
            begin
                // the last move leaves the pointer at the start of the bottom line
                cmd.scroll_wr = 1'b1;
                if (stat.move_last)
                    state_next = tcw_pkg::ST_FILL;
                else
                    state_next = tcw_pkg::ST_SCROLL_RD;
            end
            tcw_pkg::ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                    state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != tcw_pkg::ST_IDLE);

endmodule

### rtl/tcw_datapath.sv
// Datapath: item and attribute registers, cursor, screen memory, output register.
`timescale 1ns / 1ps

module tcw_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tcw_pkg::ctrl_cmd_t             cmd,
    output tcw_pkg::dp_stat_t              stat,
    input  logic [tcw_pkg::CMD_W-1:0]      command,
    input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
    input  logic [tcw_pkg::COL_IN_W-1:0]   col,
    input  logic [tcw_pkg::ROW_IN_W-1:0]   row,
    input  logic                           cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]     cfg_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tcw_pkg::OFF_W-1:0]      cursor_offset,
    output logic [tcw_pkg::CELL_W-1:0]     cell_data
);

    tcw_pkg::cmd_code_t                item_cmd_reg;
    logic [tcw_pkg::CHAR_W-1:0]        item_char_reg;
    logic [tcw_pkg::COL_IN_W-1:0]      item_col_reg;
    logic [tcw_pkg::ROW_IN_W-1:0]      item_row_reg;
    logic [tcw_pkg::ATTR_W-1:0]        attr_reg;

    logic [tcw_pkg::COL_W-1:0]         cur_col_reg;
    logic [tcw_pkg::COL_W-1:0]         cur_col_next;
    logic [tcw_pkg::ROW_W-1:0]         cur_row_reg;
    logic [tcw_pkg::ROW_W-1:0]         cur_row_next;
    logic [tcw_pkg::ADDR_W-1:0]        ptr_reg;
    logic [tcw_pkg::ADDR_W-1:0]        ptr_next;

    logic                              out_valid_reg;
    logic [tcw_pkg::OFF_W-1:0]         cursor_offset_reg;
    logic [tcw_pkg::CELL_W-1:0]        cell_data_reg;

    logic [tcw_pkg::CELL_W-1:0]        mem [tcw_pkg::CELLS];
    logic [tcw_pkg::CELL_W-1:0]        rd_data_reg;
    logic                              mem_we;
    logic [tcw_pkg::ADDR_W-1:0]        mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]        mem_wdata;
    logic                              mem_re;
    logic [tcw_pkg::ADDR_W-1:0]        mem_raddr;

    logic [tcw_pkg::ADDR_W-1:0]        cur_addr;
    logic [tcw_pkg::CT_W-1:0]          col_t;
    logic                              lf_adv;
    logic                              wrap;
    logic                              adv;
    logic                              printable;
    logic                              put_scroll;
    logic [tcw_pkg::COL_W-1:0]         put_col;
    logic [tcw_pkg::ROW_W-1:0]         put_row;
    logic [tcw_pkg::CELL_W-1:0]        blank;

    assign cur_addr  = tcw_pkg::cell_addr(cur_row_reg, cur_col_reg);
    assign printable = (item_char_reg >= tcw_pkg::CH_SPACE);
    assign blank     = {attr_reg, tcw_pkg::CH_SPACE};

    // Cursor motion for a put item
    always_comb
    begin
        col_t  = tcw_pkg::CT_W'(cur_col_reg);
        lf_adv = 1'b0;
        case (item_char_reg)
            tcw_pkg::CH_BS:
            begin
                if (cur_col_reg != '0)
                    col_t = tcw_pkg::CT_W'(cur_col_reg) - tcw_pkg::CT_W'(1);
            end
            tcw_pkg::CH_TAB:
            begin
                col_t = tcw_pkg::CT_W'((int'(cur_col_reg) / tcw_pkg::TAB_STOP + 1)
                                       * tcw_pkg::TAB_STOP);
            end
            tcw_pkg::CH_CR:
            begin
                col_t = '0;
            end
            tcw_pkg::CH_LF:
            begin
                col_t  = '0;
                lf_adv = 1'b1;
            end
            default:
            begin
                if (printable)
                    col_t = tcw_pkg::CT_W'(cur_col_reg) + tcw_pkg::CT_W'(1);
            end
        endcase
        wrap       = (int'(col_t) >= tcw_pkg::COLUMNS);
        adv        = lf_adv | wrap;
        put_col    = wrap ? '0 : tcw_pkg::COL_W'(col_t);
        put_scroll = adv && (int'(cur_row_reg) == tcw_pkg::ROWS - 1);
        if (adv && !put_scroll)
            put_row = cur_row_reg + tcw_pkg::ROW_W'(1);
        else
            put_row = cur_row_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_cmd_reg  <= tcw_pkg::cmd_code_t'(command);
            item_char_reg <= char_code;
            item_col_reg  <= col;
            item_row_reg  <= row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attr_reg <= tcw_pkg::ATTR_RESET;
        else if (cfg_we)
            attr_reg <= cfg_data;
    end

    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (cmd.do_put)
        begin
            cur_col_next = put_col;
            cur_row_next = put_row;
        end
        else if (cmd.do_clear)
        begin
            cur_col_next = '0;
            cur_row_next = '0;
        end
        else if (cmd.do_set)
        begin
            cur_col_next = tcw_pkg::sat_col(item_col_reg);
            cur_row_next = tcw_pkg::sat_row(item_row_reg);
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.do_clear || cmd.scroll_start)
            ptr_next = '0;
        else if (cmd.scroll_wr || cmd.fill_step)
            ptr_next = ptr_reg + tcw_pkg::ADDR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            ptr_reg     <= '0;
        end
        else
        begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            ptr_reg     <= ptr_next;
        end
    end

    // Memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = blank;
        if (cmd.do_put && printable)
        begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr;
            mem_wdata = {attr_reg, item_char_reg};
        end
        else if (cmd.scroll_wr)
        begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_reg;
        end
        else if (cmd.fill_step)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        mem_re    = cmd.rd_cell | cmd.scroll_rd;
        if (cmd.scroll_rd)
            mem_raddr = ptr_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        else
            mem_raddr = tcw_pkg::cell_addr(tcw_pkg::sat_row(item_row_reg),
                                           tcw_pkg::sat_col(item_col_reg));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            cursor_offset_reg <= tcw_pkg::OFF_W'(cur_addr);
            cell_data_reg     <= (item_cmd_reg == tcw_pkg::CMD_READ) ? rd_data_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_offset = cursor_offset_reg;
    assign cell_data     = cell_data_reg;

    assign stat.item_cmd   = item_cmd_reg;
    assign stat.put_scroll = put_scroll;
    assign stat.move_last  = (ptr_reg == tcw_pkg::ADDR_W'((tcw_pkg::ROWS - 1)
                                                         * tcw_pkg::COLUMNS - 1));
    assign stat.fill_last  = (ptr_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
    assign stat.out_busy   = out_valid_reg & out_stall;

endmodule

### rtl/text_console_writer_unit.sv
// Top level of the text console writer: controller, datapath and checks.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  command, char_code, col, row
//   out       output     out_valid/out_stall  cursor_offset, cell_data
//   cfg       input      cfg_valid/cfg_ready  attribute
//
// Put (no scroll), set cursor and read pass from idle through dispatch and done:
// the result is loaded into the output register as done is left, and the next
// item is taken back in idle. A put that scrolls also reads and writes each moved
// cell, then writes each bottom-line blank, in turn, through the single memory port pair.
// Clear writes one cell per cycle.
// Reset clears cursor, attribute (to 0x0F) and control; the screen memory is
// undefined until a clear or put writes it. A new item is taken while a result
// waits in the output register; a stalled result only delays the next result.
`timescale 1ns / 1ps
`include "text_console_writer_unit_assert.svh"

module text_console_writer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [tcw_pkg::CMD_W-1:0]      command,
    input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
    input  logic [tcw_pkg::COL_IN_W-1:0]   col,
    input  logic [tcw_pkg::ROW_IN_W-1:0]   row,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tcw_pkg::OFF_W-1:0]      cursor_offset,
    output logic [tcw_pkg::CELL_W-1:0]     cell_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]     attribute
);

    tcw_pkg::ctrl_cmd_t cmd;
    tcw_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .command       (command),
        .char_code     (char_code),
        .col           (col),
        .row           (row),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_data      (attribute),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_offset (cursor_offset),
        .cell_data     (cell_data)
    );

    `TCW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `TCW_ASSERT_IMPL(a_emit_slot_free, clk, rst_n, cmd.emit, !stat.out_busy)
    `TCW_ASSERT_IMPL(a_one_writer, clk, rst_n, 1'b1,
                     $onehot0({cmd.do_put, cmd.scroll_wr, cmd.fill_step}))
    `TCW_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit, out_valid)

endmodule

### dv/text_console_writer_unit_tb.sv
// Self-checking testbench for the text console writer unit.
`timescale 1ns / 1ps

module text_console_writer_unit_tb;

    import tcw_pkg::*;

    // Worst case: every item scrolls and meets the longest stall and
    // gap, taken three times over.
    localparam int LIMIT_CYCLES   = 16_000_000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_PAUSE    = 16;
    localparam int PHASE_ITEMS    = 230;
    localparam int NUM_PHASES     = 5;

    typedef struct {
        cmd_code_t           cmd;
        logic [CHAR_W-1:0]   ch;
        logic [COL_IN_W-1:0] col;
        logic [ROW_IN_W-1:0] row;
    } console_item_t;

    typedef struct {
        logic [OFF_W-1:0]  offset;
        logic [CELL_W-1:0] cell_word;
    } console_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    command = CMD_PUT;
    logic [CHAR_W-1:0]   char_code = '0;
    logic [COL_IN_W-1:0] col = '0;
    logic [ROW_IN_W-1:0] row = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [OFF_W-1:0]    cursor_offset;
    logic [CELL_W-1:0]   cell_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [ATTR_W-1:0]   attribute = '0;

    text_console_writer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .char_code     (char_code),
        .col           (col),
        .row           (row),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_offset (cursor_offset),
        .cell_data     (cell_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .attribute     (attribute)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow console: screen, cursor and attribute
    logic [CELL_W-1:0]   screen_mem [CELLS];
    logic [COL_IN_W-1:0] cur_col = '0;
    logic [ROW_IN_W-1:0] cur_row = '0;
    logic [ATTR_W-1:0]   attr_q = ATTR_RESET;

    console_item_t   pending_items [$];
    console_result_t expected_results [$];
    console_item_t   drive_item;
    console_item_t   taken_item;
    console_result_t taken_result;
    console_result_t want;

    logic in_fire = 1'b0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic holdoff_on = 1'b0;
    int   holdoff_count = 0;

    int items_queued = 0;
    int results_seen = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int cmd_count [4] = '{0, 0, 0, 0};
    int wrap_count = 0;
    int scroll_count = 0;
    int attr_writes = 0;
    int backpressure_cycles = 0;

    // Apply one item to the shadow console and work out its result.
    task automatic console_step(input console_item_t it, output console_result_t res);
        logic [CELL_W-1:0] blank;
        int                i;
        int unsigned       rsel;
        int unsigned       csel;
        blank = {attr_q, CH_SPACE};
        res.cell_word = '0;
        case (it.cmd)
            CMD_PUT:
            begin
                if (it.ch == CH_BS)
                begin
                    if (cur_col != 0)
                        cur_col = cur_col - 1'b1;
                end
                else if (it.ch == CH_TAB)
                    cur_col = COL_IN_W'((int'(cur_col) / TAB_STOP + 1) * TAB_STOP);
                else if (it.ch == CH_CR)
                    cur_col = '0;
                else if (it.ch == CH_LF)
                begin
                    cur_col = '0;
                    cur_row = cur_row + 1'b1;
                end
                else if (it.ch >= CH_SPACE)
                begin
                    screen_mem[int'(cur_row) * COLUMNS + int'(cur_col)] = {attr_q, it.ch};
                    cur_col = cur_col + 1'b1;
                end
                if (int'(cur_col) >= COLUMNS)
                begin
                    cur_col = '0;
                    cur_row = cur_row + 1'b1;
                    wrap_count++;
                end
                // scroll up one line and blank the bottom line
                if (int'(cur_row) >= ROWS)
                begin
                    for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
                        screen_mem[i] = screen_mem[i + COLUMNS];
                    for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                        screen_mem[i] = blank;
                    cur_row = ROW_IN_W'(ROWS - 1);
                    scroll_count++;
                end
            end
            CMD_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen_mem[i] = blank;
                cur_col = '0;
                cur_row = '0;
            end
            CMD_SET:
            begin
                cur_col = (int'(it.col) >= COLUMNS) ? COL_IN_W'(COLUMNS - 1) : it.col;
                cur_row = (int'(it.row) >= ROWS) ? ROW_IN_W'(ROWS - 1) : it.row;
            end
            default:
            begin
                csel = (int'(it.col) >= COLUMNS) ? COLUMNS - 1 : int'(it.col);
                rsel = (int'(it.row) >= ROWS) ? ROWS - 1 : int'(it.row);
                res.cell_word = screen_mem[rsel * COLUMNS + csel];
            end
        endcase
        res.offset = OFF_W'(int'(cur_row) * COLUMNS + int'(cur_col));
    endtask

    task automatic queue_item(input cmd_code_t cmd, input logic [CHAR_W-1:0] ch,
                              input logic [COL_IN_W-1:0] c, input logic [ROW_IN_W-1:0] r);
        console_item_t it;
        it.cmd = cmd;
        it.ch  = ch;
        it.col = c;
        it.row = r;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Mostly printable text, with every control code now and then.
    function automatic logic [CHAR_W-1:0] pick_char();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return CHAR_W'($urandom_range(255, 32));
        else if (sel < 76)
            return CH_BS;
        else if (sel < 82)
            return CH_TAB;
        else if (sel < 87)
            return CH_CR;
        else if (sel < 91)
            return CH_LF;
        return CHAR_W'($urandom_range(31));
    endfunction

    function automatic logic [COL_IN_W-1:0] pick_col();
        if ($urandom_range(99) < 80)
            return COL_IN_W'($urandom_range(COLUMNS - 1));
        return COL_IN_W'($urandom_range(127, COLUMNS));
    endfunction

    // Bias toward the last row so that wraps and line feeds scroll.
    function automatic logic [ROW_IN_W-1:0] pick_row();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return ROW_IN_W'($urandom_range(ROWS - 2));
        else if (sel < 88)
            return ROW_IN_W'(ROWS - 1);
        return ROW_IN_W'($urandom_range(31, ROWS));
    endfunction

    // Cursor moves followed by short runs of text, plus reads, clears and loose puts.
    task automatic queue_random(input int count);
        int made;
        int run;
        int unsigned sel;
        made = 0;
        while (made < count)
        begin
            sel = $urandom_range(99);
            if (sel < 2)
            begin
                queue_item(CMD_CLEAR, CHAR_W'($urandom), COL_IN_W'($urandom),
                           ROW_IN_W'($urandom));
                made++;
            end
            else if (sel < 14)
            begin
                queue_item(CMD_SET, CHAR_W'($urandom), pick_col(), pick_row());
                made++;
                run = $urandom_range(12, 1);
                repeat (run)
                begin
                    queue_item(CMD_PUT, pick_char(), COL_IN_W'($urandom),
                               ROW_IN_W'($urandom));
                    made++;
                end
            end
            else if (sel < 32)
            begin
                queue_item(CMD_READ, CHAR_W'($urandom), COL_IN_W'($urandom),
                           ROW_IN_W'($urandom));
                made++;
            end
            else
            begin
                queue_item(CMD_PUT, pick_char(), COL_IN_W'($urandom), ROW_IN_W'($urandom));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        while (results_seen < items_queued)
            @(negedge clk);
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        attribute <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        attr_writes++;
    endtask

    // Input driver: hold an item until it is taken, then offer the next one.
    always @(negedge clk)
    begin
        if (in_valid && !in_fire)
        begin
            // hold
        end
        else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            drive_item = pending_items.pop_front();
            in_valid  <= 1'b1;
            command   <= drive_item.cmd;
            char_code <= drive_item.ch;
            col       <= drive_item.col;
            row       <= drive_item.row;
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Output stall: a long hold-off when asked, random stalls otherwise.
    always @(negedge clk)
    begin
        if (!holdoff_on)
            holdoff_count <= 0;
        else if (holdoff_count < HOLDOFF_CYCLES)
            holdoff_count <= holdoff_count + 1;
        if (holdoff_on && holdoff_count < HOLDOFF_CYCLES)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: predict on each accepted item, check each accepted result.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && in_stall)
                backpressure_cycles++;
            if (cfg_valid && cfg_ready)
                attr_q = attribute;
            if (in_valid && !in_stall)
            begin
                taken_item.cmd = cmd_code_t'(command);
                taken_item.ch  = char_code;
                taken_item.col = col;
                taken_item.row = row;
                console_step(taken_item, taken_result);
                expected_results.push_back(taken_result);
                cmd_count[int'(command)]++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: cursor_offset %0d, cell_data %h",
                           cursor_offset, cell_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (cursor_offset !== want.offset)
                    begin
                        $error("cursor_offset: expected %0d, got %0d",
                               want.offset, cursor_offset);
                        fail_count++;
                    end
                    if (cell_data !== want.cell_word)
                    begin
                        $error("cell_data: expected %h, got %h", want.cell_word, cell_data);
                        fail_count++;
                    end
                end
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $error("timeout after %0d cycles, %0d of %0d results seen",
                   cycle_count, results_seen, items_queued);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, with the attribute at its reset value.
        queue_item(CMD_CLEAR, 8'h00, 7'd0, 5'd0);
        queue_item(CMD_PUT, CH_SPACE, 7'd0, 5'd0);
        queue_item(CMD_PUT, 8'hFF, 7'd0, 5'd0);
        queue_item(CMD_PUT, CH_BS, 7'd0, 5'd0);
        queue_item(CMD_PUT, CH_TAB, 7'd0, 5'd0);
        queue_item(CMD_PUT, CH_CR, 7'd0, 5'd0);
        queue_item(CMD_PUT, CH_LF, 7'd0, 5'd0);
        queue_item(CMD_PUT, 8'h00, 7'd0, 5'd0);
        queue_item(CMD_PUT, 8'h1F, 7'd0, 5'd0);
        // last cell, then wrap off the bottom line and scroll
        queue_item(CMD_SET, 8'h00, 7'd127, 5'd31);
        queue_item(CMD_PUT, 8'h41, 7'd0, 5'd0);
        queue_item(CMD_READ, 8'h00, 7'd79, 5'd23);
        queue_item(CMD_READ, 8'h00, 7'd127, 5'd31);
        // backspace held at column zero
        queue_item(CMD_SET, 8'h00, 7'd0, 5'd0);
        queue_item(CMD_PUT, CH_BS, 7'd0, 5'd0);
        // tab past the last column wraps
        queue_item(CMD_SET, 8'h00, 7'd75, 5'd3);
        queue_item(CMD_PUT, CH_TAB, 7'd0, 5'd0);
        // line feed on the last row scrolls
        queue_item(CMD_SET, 8'h00, 7'd0, 5'd24);
        queue_item(CMD_PUT, CH_LF, 7'd0, 5'd0);
        queue_item(CMD_SET, 8'h00, 7'd79, 5'd10);
        queue_item(CMD_PUT, 8'h7A, 7'd0, 5'd0);
        queue_item(CMD_READ, 8'h00, 7'd0, 5'd0);
        queue_item(CMD_READ, 8'h00, 7'd1, 5'd0);
        queue_item(CMD_CLEAR, 8'hFF, 7'd127, 5'd31);
        queue_item(CMD_READ, 8'h00, 7'd80, 5'd5);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_attribute(p == 0 ? 8'hFF : (p == 1 ? 8'h00 : ATTR_W'($urandom)));
            send_idle_pct = (p == 1) ? 86 : ((p == 3) ? 11 : 0);
            stall_pct     = (p == 2) ? 86 : ((p == 3) ? 11 : 0);
            holdoff_on    = (p == 4);
            queue_random(PHASE_ITEMS);
            wait_drained();
            holdoff_on    = 1'b0;
            send_idle_pct = 0;
            stall_pct     = 0;
        end

        $display("Ran %0d items (%0d put, %0d clear, %0d set, %0d read) in %0d cycles,",
                 items_queued, cmd_count[CMD_PUT], cmd_count[CMD_CLEAR],
                 cmd_count[CMD_SET], cmd_count[CMD_READ], cycle_count);
        $display("%0d attribute writes; cursor wrapped %0d times, screen scrolled %0d times,",
                 attr_writes, wrap_count, scroll_count);
        $display("input stalled on %0d cycles.", backpressure_cycles);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
